@@ src/wavhp_pkg.sv @@
// Shared types and constants for the RIFF/WAVE header parser.
// No dependencies; used by wavhp_out_queue and wav_header_parser_core.
package wavhp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;
  localparam logic [31:0] TAG_FMT  = 32'h666d_7420;

  localparam int          CHUNK_LIMIT_DEF = 64;
  localparam logic [31:0] FMT_MIN_SIZE    = 32'd16;
  localparam logic [15:0] FMT_PCM         = 16'd1;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_RIFF  = 3'd1,
    PH_CHUNK = 3'd2,
    PH_FMT   = 3'd3,
    PH_SKIP  = 3'd4,
    PH_DONE  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_BAD    = 2'd1,
    STATUS_TRUNC  = 2'd2,
    STATUS_FORMAT = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       first_of_file;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] sample_rate;
    logic [15:0] channel_count;
    logic [15:0] sample_bits;
    logic [31:0] pcm_length;
    logic [31:0] pcm_offset;
  } out_item_t;

endpackage

@@ src/wavhp_out_queue.sv @@
// Two-entry result queue: output register plus skid register.
// Depends on wavhp_pkg for out_item_t.
module wavhp_out_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  input  wavhp_pkg::out_item_t push_item,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_stall,
  output wavhp_pkg::out_item_t out_item
);

  wavhp_pkg::out_item_t head_r, head_nxt;
  wavhp_pkg::out_item_t skid_r, skid_nxt;
  logic                 head_valid_r, head_valid_nxt;
  logic                 skid_valid_r, skid_valid_nxt;
  logic                 pop;

  assign pop       = head_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = head_valid_r;
  assign out_item  = head_r;

  always_comb begin
    head_nxt       = head_r;
    skid_nxt       = skid_r;
    head_valid_nxt = head_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (pop) begin
      // push never coincides with a full skid stage, since full stalls input
      head_nxt       = skid_valid_r ? skid_r : push_item;
      head_valid_nxt = skid_valid_r || push_valid;
      skid_valid_nxt = 1'b0;
    end else if (push_valid) begin
      if (!head_valid_r) begin
        head_nxt       = push_item;
        head_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_item;
        skid_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      head_valid_r <= head_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  a_skid_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> head_valid_r)
    else $error("skid entry held without a head entry");

  a_head_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (head_valid_r && out_stall) |=> (head_valid_r && head_r == $past(head_r)))
    else $error("stalled result changed");

endmodule

@@ src/wav_header_parser_core.sv @@
// Top level of the RIFF/WAVE header parser: parse state and byte step logic.
// Depends on wavhp_pkg and wavhp_out_queue.
//
//   channel  | ports                          | moves
//   ---------+--------------------------------+------------------------------
//   input    | in_valid, in_stall, in_item    | one file byte per item
//   result   | out_valid, out_stall, out_item | one parse result per file
//   config   | cfg_wr_en, cfg_wr_data         | file length register write
//
// While in_stall is low, one byte item is taken per cycle; the parse state updates
// at the accepting edge; any result is registered into the two-entry output queue.
// in_stall rises only while both queue entries are held, so a stalled output
// blocks input after two pending results.
// Reset (synchronous, rst_n low) clears file length, parse state and the queue.
module wav_header_parser_core #(
  parameter int CHUNK_LIMIT = wavhp_pkg::CHUNK_LIMIT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  wavhp_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output wavhp_pkg::out_item_t out_item,
  input  logic                 cfg_wr_en,
  input  logic [31:0]          cfg_wr_data
);

  localparam int CNT_W = $clog2(CHUNK_LIMIT + 1);

  logic [31:0]       file_length_r;
  logic [31:0]       pos_r, pos_nxt;
  wavhp_pkg::phase_t phase_r, phase_nxt;
  logic [63:0]       win_r, win_nxt;
  logic [32:0]       skip_r, skip_nxt;
  logic [CNT_W-1:0]  chunks_r, chunks_nxt;
  logic              fmt_seen_r, fmt_seen_nxt;
  logic [3:0]        idx_r, idx_nxt;
  logic [31:0]       rate_r, rate_nxt;
  logic [15:0]       chans_r, chans_nxt;
  logic [15:0]       bits_r, bits_nxt;
  logic [15:0]       ftag_r, ftag_nxt;

  logic                 accept;
  logic                 res_fire;
  wavhp_pkg::status_t   res_status;
  logic [31:0]          res_len;
  logic [31:0]          res_off;
  wavhp_pkg::out_item_t res_item;

  logic [31:0] pos_inc;
  logic [31:0] tag;
  logic [31:0] raw;
  logic [31:0] size;
  logic [31:0] avail;
  logic        eoc;

  assign accept = in_valid && !in_stall;

  function automatic wavhp_pkg::status_t eof_status(input wavhp_pkg::phase_t ph);
    return (ph == wavhp_pkg::PH_RIFF || ph == wavhp_pkg::PH_FMT) ?
           wavhp_pkg::STATUS_TRUNC : wavhp_pkg::STATUS_BAD;
  endfunction

  always_comb begin
    pos_nxt      = pos_r;
    phase_nxt    = phase_r;
    win_nxt      = win_r;
    skip_nxt     = skip_r;
    chunks_nxt   = chunks_r;
    fmt_seen_nxt = fmt_seen_r;
    idx_nxt      = idx_r;
    rate_nxt     = rate_r;
    chans_nxt    = chans_r;
    bits_nxt     = bits_r;
    ftag_nxt     = ftag_r;
    res_fire     = 1'b0;
    res_status   = wavhp_pkg::STATUS_OK;
    res_len      = '0;
    res_off      = '0;
    pos_inc      = pos_r + 32'd1;
    tag          = '0;
    raw          = '0;
    size         = '0;
    avail        = '0;
    eoc          = 1'b0;

    if (accept) begin
      if (in_item.first_of_file) begin
        pos_nxt      = '0;
        phase_nxt    = wavhp_pkg::PH_RIFF;
        win_nxt      = '0;
        skip_nxt     = '0;
        chunks_nxt   = '0;
        fmt_seen_nxt = 1'b0;
        idx_nxt      = '0;
        rate_nxt     = '0;
        chans_nxt    = '0;
        bits_nxt     = '0;
        ftag_nxt     = '0;
      end
      pos_inc = pos_nxt + 32'd1;

      if (phase_nxt == wavhp_pkg::PH_IDLE || phase_nxt == wavhp_pkg::PH_DONE) begin
        // bytes outside a parse are dropped
      end else if (pos_nxt >= file_length_r) begin
        // byte beyond the end: not consumed
        res_fire   = 1'b1;
        res_status = eof_status(phase_nxt);
        phase_nxt  = wavhp_pkg::PH_DONE;
      end else begin
        case (phase_nxt)
          wavhp_pkg::PH_RIFF: begin
            // RIFF size bytes 4..7 stay out of the window
            if (pos_nxt < 32'd4 || pos_nxt >= 32'd8) begin
              win_nxt = {win_nxt[55:0], in_item.file_byte};
            end
            if (pos_nxt == 32'd11) begin
              if (win_nxt != {wavhp_pkg::TAG_RIFF, wavhp_pkg::TAG_WAVE}) begin
                res_fire   = 1'b1;
                res_status = wavhp_pkg::STATUS_BAD;
                phase_nxt  = wavhp_pkg::PH_DONE;
              end else begin
                phase_nxt = wavhp_pkg::PH_CHUNK;
                idx_nxt   = '0;
                win_nxt   = '0;
              end
            end
          end
          wavhp_pkg::PH_CHUNK: begin
            win_nxt = {win_nxt[55:0], in_item.file_byte};
            idx_nxt = idx_nxt + 4'd1;
            if (idx_nxt >= 4'd8) begin
              idx_nxt    = '0;
              tag        = win_nxt[63:32];
              raw        = win_nxt[31:0];
              size       = {raw[7:0], raw[15:8], raw[23:16], raw[31:24]};
              chunks_nxt = chunks_nxt + CNT_W'(1);
              if (tag == wavhp_pkg::TAG_DATA) begin
                avail = (file_length_r > pos_inc) ? (file_length_r - pos_inc) : '0;
                res_fire  = 1'b1;
                phase_nxt = wavhp_pkg::PH_DONE;
                if (!fmt_seen_nxt) begin
                  res_status = wavhp_pkg::STATUS_BAD;
                end else begin
                  res_len = (size < avail) ? size : avail;
                  res_off = pos_inc;
                  res_status = (res_len == '0) ? wavhp_pkg::STATUS_TRUNC :
                                                 wavhp_pkg::STATUS_OK;
                end
              end else begin
                // body plus pad byte when the size is odd
                skip_nxt = {1'b0, size} + {32'd0, size[0]};
                if (tag == wavhp_pkg::TAG_FMT && size >= wavhp_pkg::FMT_MIN_SIZE) begin
                  phase_nxt = wavhp_pkg::PH_FMT;
                  idx_nxt   = '0;
                end else if (skip_nxt == '0) begin
                  eoc = 1'b1;
                end else begin
                  phase_nxt = wavhp_pkg::PH_SKIP;
                end
              end
            end
          end
          wavhp_pkg::PH_FMT: begin
            case (idx_nxt)
              4'd0:    ftag_nxt[7:0]   = in_item.file_byte;
              4'd1:    ftag_nxt[15:8]  = in_item.file_byte;
              4'd2:    chans_nxt[7:0]  = in_item.file_byte;
              4'd3:    chans_nxt[15:8] = in_item.file_byte;
              4'd4:    rate_nxt[7:0]   = in_item.file_byte;
              4'd5:    rate_nxt[15:8]  = in_item.file_byte;
              4'd6:    rate_nxt[23:16] = in_item.file_byte;
              4'd7:    rate_nxt[31:24] = in_item.file_byte;
              4'd14:   bits_nxt[7:0]   = in_item.file_byte;
              4'd15:   bits_nxt[15:8]  = in_item.file_byte;
              default: ;
            endcase
            if (idx_nxt == 4'd15) begin
              idx_nxt = '0;
              if (ftag_nxt != wavhp_pkg::FMT_PCM) begin
                res_fire   = 1'b1;
                res_status = wavhp_pkg::STATUS_FORMAT;
                phase_nxt  = wavhp_pkg::PH_DONE;
              end else begin
                fmt_seen_nxt = 1'b1;
                skip_nxt     = skip_nxt - 33'd16;
                if (skip_nxt == '0) begin
                  eoc = 1'b1;
                end else begin
                  phase_nxt = wavhp_pkg::PH_SKIP;
                end
              end
            end else begin
              idx_nxt = idx_nxt + 4'd1;
            end
          end
          wavhp_pkg::PH_SKIP: begin
            if (skip_nxt != '0) begin
              skip_nxt = skip_nxt - 33'd1;
            end
            if (skip_nxt == '0) begin
              eoc = 1'b1;
            end
          end
          default: ;
        endcase

        // end of a chunk body: chunk limit check, else next header
        if (eoc) begin
          if (chunks_nxt >= CNT_W'(CHUNK_LIMIT)) begin
            res_fire   = 1'b1;
            res_status = wavhp_pkg::STATUS_BAD;
            phase_nxt  = wavhp_pkg::PH_DONE;
          end else begin
            phase_nxt = wavhp_pkg::PH_CHUNK;
            idx_nxt   = '0;
            win_nxt   = '0;
          end
        end

        pos_nxt = pos_inc;
        if (!res_fire && phase_nxt != wavhp_pkg::PH_DONE && pos_inc >= file_length_r) begin
          res_fire   = 1'b1;
          res_status = eof_status(phase_nxt);
          phase_nxt  = wavhp_pkg::PH_DONE;
        end
      end
    end

    // all fields but status read zero on a failed parse
    res_item.status = res_status;
    if (res_status == wavhp_pkg::STATUS_OK) begin
      res_item.sample_rate   = rate_nxt;
      res_item.channel_count = chans_nxt;
      res_item.sample_bits   = bits_nxt;
      res_item.pcm_length    = res_len;
      res_item.pcm_offset    = res_off;
    end else begin
      res_item.sample_rate   = '0;
      res_item.channel_count = '0;
      res_item.sample_bits   = '0;
      res_item.pcm_length    = '0;
      res_item.pcm_offset    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_length_r <= '0;
      pos_r         <= '0;
      phase_r       <= wavhp_pkg::PH_IDLE;
      win_r         <= '0;
      skip_r        <= '0;
      chunks_r      <= '0;
      fmt_seen_r    <= 1'b0;
      idx_r         <= '0;
      rate_r        <= '0;
      chans_r       <= '0;
      bits_r        <= '0;
      ftag_r        <= '0;
    end else begin
      if (cfg_wr_en) begin
        file_length_r <= cfg_wr_data;
      end
      pos_r      <= pos_nxt;
      phase_r    <= phase_nxt;
      win_r      <= win_nxt;
      skip_r     <= skip_nxt;
      chunks_r   <= chunks_nxt;
      fmt_seen_r <= fmt_seen_nxt;
      idx_r      <= idx_nxt;
      rate_r     <= rate_nxt;
      chans_r    <= chans_nxt;
      bits_r     <= bits_nxt;
      ftag_r     <= ftag_nxt;
    end
  end

  wavhp_out_queue u_out_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (res_fire),
    .push_item  (res_item),
    .full       (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

  a_stall_means_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no pending result");

  a_chunk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    chunks_r <= CNT_W'(CHUNK_LIMIT))
    else $error("chunk count past limit");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == wavhp_pkg::PH_IDLE && !(accept && in_item.first_of_file))
    |=> (phase_r == wavhp_pkg::PH_IDLE && !out_valid))
    else $error("left idle without a first byte");

  a_fmt_body: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == wavhp_pkg::PH_FMT) |-> (skip_r >= 33'd16))
    else $error("fmt body shorter than its fields");

  a_hdr_index: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == wavhp_pkg::PH_CHUNK) |-> (idx_r < 4'd8))
    else $error("chunk header index out of range");

endmodule

@@ dv/tb_wav_header_parser_core.sv @@
// Self-checking testbench for wav_header_parser_core: byte-stream RIFF/WAVE files in,
// one parse result per file out, compared against an in-bench parser model.
// Depends on wavhp_pkg and the wav_header_parser_core RTL.
module tb_wav_header_parser_core;
  import wavhp_pkg::*;

  localparam int unsigned RUN_LIMIT     = 600000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned ITEM_TARGET   = 1400;

  localparam out_item_t NO_RESULT    = '0;
  localparam out_item_t TRUNC_RESULT = '{STATUS_TRUNC, 32'd0, 16'd0, 16'd0, 32'd0, 32'd0};
  localparam out_item_t BAD_RESULT   = '{STATUS_BAD, 32'd0, 16'd0, 16'd0, 32'd0, 32'd0};

  typedef enum int {
    FILE_PCM, FILE_NO_FMT, FILE_EMPTY_DATA, FILE_NON_PCM, FILE_SHORT_FMT,
    FILE_BAD_TAG, FILE_NOISE, FILE_CUT, FILE_CHUNK_LIMIT, FILE_KINDS
  } file_kind_t;

  typedef struct packed {
    logic        is_cfg;
    logic [31:0] value;
    in_item_t    item;
    logic        fixed;
    out_item_t   want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;

  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned bytes_parsed = 0;
  bit          calm = 1'b0;
  bit          hold_long = 1'b0;

  out_item_t   parse_results_due[$];
  logic [7:0]  wav_bytes[$];
  logic [31:0] file_len_next;

  // parser model state
  logic [31:0] file_len_q;
  phase_t      ph;
  logic [31:0] pos_q;
  logic [63:0] hwin;
  logic [32:0] skip_left;
  logic [6:0]  chunk_cnt;
  logic        fmt_ok;
  logic [3:0]  fidx;
  logic [31:0] rate_q;
  logic [15:0] chan_q;
  logic [15:0] bits_q;
  logic [15:0] ftag_q;

  // Header cases whose outcome is plain from the spec carry a fixed result.
  plan_row_t directed_plan [0:24] = '{
    // idle after reset, file length 0, then a byte after done
    '{1'b0, 32'd0, '{8'h00, 1'b0}, 1'b0, NO_RESULT},
    '{1'b0, 32'd0, '{8'h52, 1'b1}, 1'b1, TRUNC_RESULT},
    '{1'b0, 32'd0, '{8'hff, 1'b0}, 1'b0, NO_RESULT},
    // 12-byte file with a broken WAVE tag
    '{1'b1, 32'd12, '{8'h00, 1'b0}, 1'b0, NO_RESULT},
    '{1'b0, 32'd0, '{8'h52, 1'b1}, 1'b0, NO_RESULT},
    '{1'b0, 32'd0, '{8'h49, 1'b0}, 1'b0, NO_RESULT},
    '{1'b0, 32'd0, '{8'h46, 1'b0}, 1'b0, NO_RESULT},
    '{1'b0, 32'd0, '{8'h46, 1'b0}, 1'b0, NO_RESULT},
    '{1'b0, 32'd0, '{8'h00, 1'b0}, 1'b0, NO_RESULT},
    '{1'b0, 32'd0, '{8'hff, 1'b0}, 1'b0, NO_RESULT},
    '{1'b0, 32'd0, '{8'h00, 1'b0}, 1'b0, NO_RESULT},
    '{1'b0, 32'd0, '{8'hff, 1'b0}, 1'b0, NO_RESULT},
    '{1'b0, 32'd0, '{8'h57, 1'b0}, 1'b0, NO_RESULT},
    '{1'b0, 32'd0, '{8'h41, 1'b0}, 1'b0, NO_RESULT},
    '{1'b0, 32'd0, '{8'h56, 1'b0}, 1'b0, NO_RESULT},
    '{1'b0, 32'd0, '{8'h46, 1'b0}, 1'b1, BAD_RESULT},
    // file ends inside the RIFF header
    '{1'b1, 32'd3, '{8'h00, 1'b0}, 1'b0, NO_RESULT},
    '{1'b0, 32'd0, '{8'h52, 1'b1}, 1'b0, NO_RESULT},
    '{1'b0, 32'd0, '{8'h49, 1'b0}, 1'b0, NO_RESULT},
    '{1'b0, 32'd0, '{8'h46, 1'b0}, 1'b1, TRUNC_RESULT},
    // restart in the middle of a header, largest file length
    '{1'b1, 32'hffff_ffff, '{8'h00, 1'b0}, 1'b0, NO_RESULT},
    '{1'b0, 32'd0, '{8'h52, 1'b1}, 1'b0, NO_RESULT},
    '{1'b0, 32'd0, '{8'h49, 1'b0}, 1'b0, NO_RESULT},
    '{1'b0, 32'd0, '{8'h52, 1'b1}, 1'b0, NO_RESULT},
    '{1'b0, 32'd0, '{8'h49, 1'b0}, 1'b0, NO_RESULT}
  };

  wav_header_parser_core #(
    .CHUNK_LIMIT(CHUNK_LIMIT_DEF)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("tb_wav_header_parser_core NOT OK");
      $finish;
    end
  end

  // ---------------- parser model ----------------

  function automatic void wav_parse_clear();
    pos_q = '0;
    ph = PH_IDLE;
    hwin = '0;
    skip_left = '0;
    chunk_cnt = '0;
    fmt_ok = 1'b0;
    fidx = '0;
    rate_q = '0;
    chan_q = '0;
    bits_q = '0;
    ftag_q = '0;
  endfunction

  function automatic out_item_t parse_end(input status_t st, input logic [31:0] len,
                                          input logic [31:0] off);
    out_item_t r;
    r = '0;
    r.status = st;
    ph = PH_DONE;
    if (st == STATUS_OK) begin
      r.sample_rate = rate_q;
      r.channel_count = chan_q;
      r.sample_bits = bits_q;
      r.pcm_length = len;
      r.pcm_offset = off;
    end
    return r;
  endfunction

  function automatic status_t eof_code();
    return (ph == PH_RIFF || ph == PH_FMT) ? STATUS_TRUNC : STATUS_BAD;
  endfunction

  function automatic bit chunk_end(output out_item_t r);
    r = '0;
    if (chunk_cnt >= CHUNK_LIMIT_DEF) begin
      r = parse_end(STATUS_BAD, '0, '0);
      return 1'b1;
    end
    ph = PH_CHUNK;
    fidx = '0;
    hwin = '0;
    return 1'b0;
  endfunction

  function automatic bit header_done(output out_item_t r);
    logic [31:0] tagv;
    logic [31:0] sz;
    logic [31:0] avail;
    logic [31:0] lenv;
    r = '0;
    tagv = hwin[63:32];
    sz = {hwin[7:0], hwin[15:8], hwin[23:16], hwin[31:24]};
    chunk_cnt = chunk_cnt + 7'd1;
    if (tagv == TAG_DATA) begin
      if (!fmt_ok) begin
        r = parse_end(STATUS_BAD, '0, '0);
        return 1'b1;
      end
      avail = (file_len_q > pos_q) ? file_len_q - pos_q : 32'd0;
      lenv = (sz < avail) ? sz : avail;
      if (lenv == 0) r = parse_end(STATUS_TRUNC, '0, '0);
      else r = parse_end(STATUS_OK, lenv, pos_q);
      return 1'b1;
    end
    skip_left = {1'b0, sz} + 33'(sz[0]);
    if (tagv == TAG_FMT && sz >= FMT_MIN_SIZE) begin
      ph = PH_FMT;
      fidx = '0;
      return 1'b0;
    end
    if (skip_left == 0) return chunk_end(r);
    ph = PH_SKIP;
    return 1'b0;
  endfunction

  function automatic bit fmt_step(input logic [7:0] b, output out_item_t r);
    int unsigned fi;
    r = '0;
    fi = 32'(fidx);
    case (fi)
      0: ftag_q[7:0] = b;
      1: ftag_q[15:8] = b;
      2: chan_q[7:0] = b;
      3: chan_q[15:8] = b;
      4, 5, 6, 7: rate_q[8*(fi-4) +: 8] = b;
      14: bits_q[7:0] = b;
      15: bits_q[15:8] = b;
      default: ;
    endcase
    fidx = fidx + 4'd1;
    if (fi != 15) return 1'b0;
    if (ftag_q != FMT_PCM) begin
      r = parse_end(STATUS_FORMAT, '0, '0);
      return 1'b1;
    end
    fmt_ok = 1'b1;
    skip_left = skip_left - 33'd16;
    if (skip_left == 0) return chunk_end(r);
    ph = PH_SKIP;
    return 1'b0;
  endfunction

  // Steps the model by one byte; busy is low when the byte is ignored.
  function automatic bit wav_parse_byte(input in_item_t it, output out_item_t res,
                                        output bit busy);
    logic [31:0] at;
    logic [7:0]  b;
    bit          done;
    res = '0;
    busy = 1'b0;
    done = 1'b0;
    b = it.file_byte;
    if (it.first_of_file) begin
      wav_parse_clear();
      ph = PH_RIFF;
    end
    if (ph == PH_IDLE || ph == PH_DONE) return 1'b0;
    busy = 1'b1;
    if (pos_q >= file_len_q) begin
      res = parse_end(eof_code(), '0, '0);
      return 1'b1;
    end
    at = pos_q;
    pos_q = pos_q + 32'd1;
    case (ph)
      PH_RIFF: begin
        // RIFF size bytes are not kept
        if (at < 4 || at >= 8) hwin = {hwin[55:0], b};
        if (at == 11) begin
          if (hwin != {TAG_RIFF, TAG_WAVE}) begin
            res = parse_end(STATUS_BAD, '0, '0);
            return 1'b1;
          end
          ph = PH_CHUNK;
          fidx = '0;
          hwin = '0;
        end
      end
      PH_CHUNK: begin
        hwin = {hwin[55:0], b};
        fidx = fidx + 4'd1;
        if (fidx >= 4'd8) begin
          fidx = '0;
          done = header_done(res);
        end
      end
      PH_FMT: done = fmt_step(b, res);
      default: begin
        if (skip_left != 0) skip_left = skip_left - 33'd1;
        if (skip_left == 0) done = chunk_end(res);
      end
    endcase
    if (done) return 1'b1;
    if (ph != PH_DONE && pos_q >= file_len_q) begin
      res = parse_end(eof_code(), '0, '0);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // ---------------- file builder ----------------

  function automatic void put_le(input logic [31:0] v, input int n);
    for (int k = 0; k < n; k++) wav_bytes.push_back(v[8*k +: 8]);
  endfunction

  function automatic void put_tag(input logic [31:0] tag);
    for (int k = 3; k >= 0; k--) wav_bytes.push_back(tag[8*k +: 8]);
  endfunction

  function automatic void put_noise(input int unsigned n);
    repeat (n) wav_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void put_chunk(input logic [31:0] tag, input int unsigned body_len);
    put_tag(tag);
    put_le(body_len, 4);
    put_noise(body_len + body_len % 2);
  endfunction

  function automatic void build_file(input file_kind_t kind);
    int unsigned junk;
    int unsigned spot;
    int unsigned fsize;
    int unsigned nfmt;
    int unsigned m;
    logic [15:0] ptag;
    logic [31:0] dlen;
    wav_bytes.delete();
    if (kind == FILE_NOISE) begin
      put_noise($urandom_range(1, 40));
    end else begin
      put_tag(TAG_RIFF);
      put_le($urandom, 4);
      put_tag(TAG_WAVE);
      if (kind == FILE_BAD_TAG) begin
        spot = $urandom_range(0, 7);
        if (spot >= 4) spot += 4;
        wav_bytes[spot] ^= 8'($urandom_range(1, 255));
      end
      junk = (kind == FILE_CHUNK_LIMIT) ? CHUNK_LIMIT_DEF : $urandom_range(0, 2);
      repeat (junk)
        put_chunk($urandom, (kind == FILE_CHUNK_LIMIT) ? $urandom_range(0, 1)
                                                       : $urandom_range(0, 9));
      if (kind == FILE_SHORT_FMT) begin
        put_chunk(TAG_FMT, $urandom_range(0, 15));
      end else if (kind != FILE_NO_FMT) begin
        nfmt = ($urandom_range(0, 5) == 0) ? 2 : 1;
        repeat (nfmt) begin
          fsize = $urandom_range(16, 21);
          ptag = FMT_PCM;
          if (kind == FILE_NON_PCM)
            do ptag = 16'($urandom_range(0, 65535)); while (ptag == FMT_PCM);
          put_tag(TAG_FMT);
          put_le(fsize, 4);
          put_le(32'(ptag), 2);
          put_noise(fsize - 2 + fsize % 2);
        end
        if ($urandom_range(0, 3) == 0) put_chunk($urandom, $urandom_range(0, 9));
      end
      case ($urandom_range(0, 3))
        0: dlen = $urandom_range(1, 8);
        1: dlen = $urandom_range(1, 64);
        2: dlen = $urandom;
        default: dlen = 32'hffff_ffff;
      endcase
      if (kind == FILE_EMPTY_DATA) dlen = '0;
      put_tag(TAG_DATA);
      put_le(dlen, 4);
      put_noise($urandom_range(0, 4));
    end
    m = $urandom_range(0, 9);
    if (kind == FILE_CHUNK_LIMIT || kind == FILE_CUT || m <= 5)
      file_len_next = wav_bytes.size();
    else if (m <= 7)
      file_len_next = $urandom_range(0, wav_bytes.size() - 1);
    else if (m == 8)
      file_len_next = wav_bytes.size() + $urandom_range(1, 100);
    else
      file_len_next = 32'hffff_ffff;
  endfunction

  // ---------------- drivers ----------------

  task automatic send_byte(input in_item_t it, input bit use_given, input out_item_t given);
    int unsigned gap;
    out_item_t   res;
    bit          busy;
    bit          got;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    got = wav_parse_byte(it, res, busy);
    if (use_given) begin
      got = 1'b1;
      res = given;
    end
    if (got) parse_results_due.push_back(res);
    if (busy) bytes_parsed++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (parse_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [31:0] v);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    file_len_q = v;
    cfg_wr_en <= 1'b0;
  endtask

  // ---------------- result side ----------------

  initial begin
    int unsigned hold;
    forever begin
      hold = calm ? 0 : $urandom_range(0, 11);
      if (hold_long) begin
        hold = LONG_HOLD;
        hold_long = 1'b0;
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (parse_results_due.size() == 0) begin
        report_mismatch("unexpected result, status", 32'(out_item.status), '0);
      end else begin
        want = parse_results_due.pop_front();
        if (out_item.status !== want.status)
          report_mismatch("status", 32'(out_item.status), 32'(want.status));
        if (out_item.sample_rate !== want.sample_rate)
          report_mismatch("sample_rate", out_item.sample_rate, want.sample_rate);
        if (out_item.channel_count !== want.channel_count)
          report_mismatch("channel_count", 32'(out_item.channel_count),
                          32'(want.channel_count));
        if (out_item.sample_bits !== want.sample_bits)
          report_mismatch("sample_bits", 32'(out_item.sample_bits), 32'(want.sample_bits));
        if (out_item.pcm_length !== want.pcm_length)
          report_mismatch("pcm_length", out_item.pcm_length, want.pcm_length);
        if (out_item.pcm_offset !== want.pcm_offset)
          report_mismatch("pcm_offset", out_item.pcm_offset, want.pcm_offset);
      end
    end
  end

  // ---------------- stimulus ----------------

  initial begin
    int unsigned i;
    int unsigned cut_at;
    int unsigned r;
    int          file_no;
    in_item_t    one;
    file_kind_t  kind;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    wav_parse_clear();
    file_len_q = '0;

    foreach (directed_plan[n]) begin
      if (directed_plan[n].is_cfg) write_cfg(directed_plan[n].value);
      else send_byte(directed_plan[n].item, directed_plan[n].fixed, directed_plan[n].want);
    end

    file_no = 0;
    while (bytes_parsed < ITEM_TARGET) begin
      if (file_no == 6) begin
        // one-byte files, each ends at once; receiver holds off so the queue backs up
        write_cfg(32'd1);
        calm = 1'b1;
        hold_long = 1'b1;
        repeat (8) begin
          one.file_byte = 8'($urandom_range(0, 255));
          one.first_of_file = 1'b1;
          send_byte(one, 1'b0, NO_RESULT);
        end
      end
      if (file_no < FILE_KINDS) begin
        kind = file_kind_t'(file_no);
      end else begin
        r = $urandom_range(0, 29);
        if (r == 0) kind = FILE_CHUNK_LIMIT;
        else if (r <= 14) kind = FILE_PCM;
        else if (r <= 16) kind = FILE_NO_FMT;
        else if (r <= 18) kind = FILE_EMPTY_DATA;
        else if (r <= 20) kind = FILE_NON_PCM;
        else if (r <= 22) kind = FILE_SHORT_FMT;
        else if (r <= 24) kind = FILE_BAD_TAG;
        else if (r <= 26) kind = FILE_NOISE;
        else kind = FILE_CUT;
      end
      build_file(kind);
      write_cfg(file_len_next);
      calm = ($urandom_range(0, 3) == 0);
      cut_at = (kind == FILE_CUT) ? $urandom_range(1, wav_bytes.size() - 1)
                                  : wav_bytes.size();
      for (i = 0; i < wav_bytes.size(); i++) begin
        // length lowered to at most the bytes already taken
        if (i == cut_at) write_cfg($urandom_range(0, i));
        one.file_byte = wav_bytes[i];
        one.first_of_file = (i == 0);
        send_byte(one, 1'b0, NO_RESULT);
      end
      file_no++;
    end

    wait_drained();
    if (mismatches == 0) $display("tb_wav_header_parser_core OK");
    else $display("tb_wav_header_parser_core NOT OK");
    $finish;
  end

endmodule
